/* hdl/lco_pkg.sv */
// shared constants and types of the label colour overlay
package lco_pkg;

    // field widths
    localparam int LABEL_BITS     = 16;
    localparam int INTEN_BITS     = 8;
    localparam int CHAN_BITS      = 8;
    localparam int WEIGHT_BITS    = 9;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 9;
    localparam int NUM_CHAN       = 3;

    // label times pi keeps its low 32 bits
    localparam int FRAC_BITS = 32;
    localparam int PROD_BITS = LABEL_BITS + FRAC_BITS;

    // fraction part of pi with 32 fraction bits
    localparam logic [FRAC_BITS-1:0] PI_FRAC = 32'h243F_6A88;

    // one in q0.24, held in 25 bits
    localparam logic [24:0] ONE_Q24 = 25'h100_0000;

    // blend weight reset value and upper limit
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 9'd192;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX   = 9'd256;

    // reciprocal of 255 for 16-bit dividends, shift 23
    localparam logic [32:0] RECIP_255 = 33'h0_0000_8081;

    // channel lanes
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;
    typedef logic [NUM_CHAN-1:0][CHAN_BITS-1:0] rgb_t;

    // configuration register indexes
    localparam cfg_index_t REG_DARK_BACKGROUND = 2'd0;
    localparam cfg_index_t REG_BLEND_WEIGHT    = 2'd1;

    // how a pixel gets its colour
    typedef enum logic [1:0] {
        MODE_HSV,
        MODE_WHITE,
        MODE_BLACK
    } colour_mode_t;

    // hue sectors of the hsv wheel
    typedef enum logic [2:0] {
        SECT_RED_YELLOW,
        SECT_YELLOW_GREEN,
        SECT_GREEN_CYAN,
        SECT_CYAN_BLUE,
        SECT_BLUE_MAGENTA,
        SECT_MAGENTA_RED
    } sector_t;

endpackage

/* hdl/lco_channels.sv */
// stream and configuration channel interfaces of the label colour overlay

interface lco_pixel_in_if;
    logic                             valid;
    logic                             ready;
    logic [lco_pkg::INTEN_BITS-1:0]   intensity;
    logic [lco_pkg::LABEL_BITS-1:0]   region_label;

    modport source (output valid, output intensity, output region_label, input ready);
    modport sink   (input valid, input intensity, input region_label, output ready);
endinterface

interface lco_pixel_out_if;
    logic                             valid;
    logic                             ready;
    logic [lco_pkg::CHAN_BITS-1:0]    red;
    logic [lco_pkg::CHAN_BITS-1:0]    green;
    logic [lco_pkg::CHAN_BITS-1:0]    blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface lco_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [lco_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [lco_pkg::CFG_DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/label_color_overlay.sv */
// top level: label colour overlay pipeline
//
// One overlay pixel per input pixel, one pixel a clock sustained while the
// output is not held. Each pixel runs through a seven-stage pipeline (label
// times pi, hue and saturation, hsv products, channel colour, blend factor,
// intensity product, divide by 65280). A result is offered from the stage 7
// register and leaves when pixel_out.ready is high. Every stage has its own
// valid bit and moves up whenever the stage after it is empty or moving, so a
// held output only stops the pipeline once all stages are full;
// pixel_in.ready is that chain of stage enables. Configuration writes are
// taken every cycle (cfg.ready is always high) and should only be made while
// no pixel is in flight; writes to an index beyond blend_weight are dropped.
// A blend weight above 256 acts as 256.
module label_color_overlay (
    input  logic            clk,
    input  logic            rst_n,
    lco_pixel_in_if.sink    pixel_in,
    lco_pixel_out_if.source pixel_out,
    lco_cfg_if.sink         cfg
);
    import lco_pkg::*;

    // configuration registers
    logic                   dark_background_reg;
    logic [WEIGHT_BITS-1:0] blend_weight_reg;

    // stage valid bits and enables, stage 1 to 7
    logic [7:1] valid_reg;
    logic [7:1] stage_en;

    // stage 1: fraction of label times pi
    logic [FRAC_BITS-1:0]   frac1_reg, frac1_next;
    colour_mode_t           mode1_reg, mode1_next;
    logic [INTEN_BITS-1:0]  inten1_reg;

    // stage 2: saturation, sector and fraction in sector
    logic [23:0]            sat2_reg, sat2_next;
    logic [23:0]            f2_reg, f2_next;
    logic [24:0]            omf2_reg, omf2_next;
    sector_t                sect2_reg, sect2_next;
    colour_mode_t           mode2_reg;
    logic [INTEN_BITS-1:0]  inten2_reg;

    // stage 3: hsv products
    logic [23:0]            p3_reg, p3_next;
    logic [23:0]            qh3_reg, qh3_next;
    logic [23:0]            th3_reg, th3_next;
    sector_t                sect3_reg;
    colour_mode_t           mode3_reg;
    logic [INTEN_BITS-1:0]  inten3_reg;

    // stage 4: colour channels
    rgb_t                   colour4_reg, colour4_next;
    logic [INTEN_BITS-1:0]  inten4_reg;

    // stage 5: blend factor per channel
    logic [NUM_CHAN-1:0][15:0] k5_reg, k5_next;
    logic [INTEN_BITS-1:0]     inten5_reg;

    // stage 6: numerator per channel
    logic [NUM_CHAN-1:0][23:0] num6_reg, num6_next;

    // stage 7: output register
    rgb_t                   out7_reg, out7_next;

    // channel value (255 * x) >> 24 for x in q0.24
    function automatic logic [CHAN_BITS-1:0] chan_q24(input logic [24:0] x);
        logic [32:0] y;
        y = {x, 8'b0} - 33'(x);
        return y[31:24];
    endfunction

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_background_reg <= 1'b0;
            blend_weight_reg    <= WEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DARK_BACKGROUND: dark_background_reg <= cfg.data[0];
                REG_BLEND_WEIGHT:    blend_weight_reg    <= cfg.data[WEIGHT_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // stage enable chain, a stage moves when it is empty or the next one moves
    always_comb
    begin
        stage_en[7] = !valid_reg[7] || pixel_out.ready;
        for (int s = 6; s >= 1; s--)
        begin
            stage_en[s] = !valid_reg[s] || stage_en[s+1];
        end
    end

    assign pixel_in.ready = stage_en[1];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[1])
            begin
                valid_reg[1] <= pixel_in.valid;
            end
            for (int s = 2; s <= 7; s++)
            begin
                if (stage_en[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    // stage 1: label times pi, colour mode
    always_comb
    begin
        logic [PROD_BITS-1:0] prod;
        prod       = PROD_BITS'(pixel_in.region_label) * PROD_BITS'(PI_FRAC);
        frac1_next = prod[FRAC_BITS-1:0];
        if (pixel_in.region_label != '0)
        begin
            mode1_next = MODE_HSV;
        end
        else if (dark_background_reg)
        begin
            mode1_next = MODE_BLACK;
        end
        else
        begin
            mode1_next = MODE_WHITE;
        end
    end

    // stage 2: saturation; hue times six splits into sector and fraction
    always_comb
    begin
        logic [23:0] hue;
        logic [31:0] frac4;
        logic [26:0] h6;
        hue        = frac1_reg[31:8];
        frac4      = {frac1_reg[29:0], 2'b00};
        h6         = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
        sat2_next  = {1'b1, frac4[31:9]};
        f2_next    = h6[23:0];
        omf2_next  = ONE_Q24 - {1'b0, h6[23:0]};
        sect2_next = sector_t'(h6[26:24]);
    end

    // stage 3: p, s*f and s*(1-f)
    always_comb
    begin
        logic [47:0] qprod;
        logic [48:0] tprod;
        logic [24:0] pfull;
        qprod    = 48'(sat2_reg) * 48'(f2_reg);
        tprod    = 49'(sat2_reg) * 49'(omf2_reg);
        pfull    = ONE_Q24 - {1'b0, sat2_reg};
        p3_next  = pfull[23:0];
        qh3_next = qprod[47:24];
        th3_next = tprod[47:24];
    end

    // stage 4: channel colours by sector, white and black override
    always_comb
    begin
        logic [CHAN_BITS-1:0] pc, qc, tc, vc;
        pc = chan_q24({1'b0, p3_reg});
        qc = chan_q24(ONE_Q24 - {1'b0, qh3_reg});
        tc = chan_q24(ONE_Q24 - {1'b0, th3_reg});
        vc = '1;
        case (sect3_reg)
            SECT_RED_YELLOW:   colour4_next = {pc, tc, vc};
            SECT_YELLOW_GREEN: colour4_next = {pc, vc, qc};
            SECT_GREEN_CYAN:   colour4_next = {tc, vc, pc};
            SECT_CYAN_BLUE:    colour4_next = {vc, qc, pc};
            SECT_BLUE_MAGENTA: colour4_next = {vc, pc, tc};
            default:           colour4_next = {qc, pc, vc};
        endcase
        case (mode3_reg)
            MODE_WHITE: colour4_next = '1;
            MODE_BLACK: colour4_next = '0;
            default:    ;
        endcase
    end

    // stage 5: k = 255 * (256 - w) + w * c
    always_comb
    begin
        logic [WEIGHT_BITS-1:0] w;
        logic [WEIGHT_BITS-1:0] inv;
        logic [16:0]            base;
        logic [16:0]            ksum;
        w    = (blend_weight_reg > WEIGHT_MAX) ? WEIGHT_MAX : blend_weight_reg;
        inv  = WEIGHT_MAX - w;
        base = {inv, 8'b0} - 17'(inv);
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            ksum       = base + 17'(w) * 17'(colour4_reg[c]);
            k5_next[c] = ksum[15:0];
        end
    end

    // stage 6: numerator = intensity * k
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            num6_next[c] = 24'(inten5_reg) * 24'(k5_reg[c]);
        end
    end

    // stage 7: divide by 65280 as shift by 8 then reciprocal of 255
    always_comb
    begin
        logic [32:0] quot;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            quot         = 33'(num6_reg[c][23:8]) * RECIP_255;
            out7_next[c] = quot[30:23];
        end
    end

    // pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            frac1_reg  <= frac1_next;
            mode1_reg  <= mode1_next;
            inten1_reg <= pixel_in.intensity;
        end
        if (stage_en[2])
        begin
            sat2_reg   <= sat2_next;
            f2_reg     <= f2_next;
            omf2_reg   <= omf2_next;
            sect2_reg  <= sect2_next;
            mode2_reg  <= mode1_reg;
            inten2_reg <= inten1_reg;
        end
        if (stage_en[3])
        begin
            p3_reg     <= p3_next;
            qh3_reg    <= qh3_next;
            th3_reg    <= th3_next;
            sect3_reg  <= sect2_reg;
            mode3_reg  <= mode2_reg;
            inten3_reg <= inten2_reg;
        end
        if (stage_en[4])
        begin
            colour4_reg <= colour4_next;
            inten4_reg  <= inten3_reg;
        end
        if (stage_en[5])
        begin
            k5_reg     <= k5_next;
            inten5_reg <= inten4_reg;
        end
        if (stage_en[6])
        begin
            num6_reg <= num6_next;
        end
        if (stage_en[7])
        begin
            out7_reg <= out7_next;
        end
    end

    // output beat
    assign pixel_out.valid = valid_reg[7];
    assign pixel_out.red   = out7_reg[CH_RED];
    assign pixel_out.green = out7_reg[CH_GREEN];
    assign pixel_out.blue  = out7_reg[CH_BLUE];

endmodule
